### rtl/binary_cross_morphology_defines.svh
// Assertion macros for the binary cross morphology block.
`ifndef BINARY_CROSS_MORPHOLOGY_DEFINES_SVH
`define BINARY_CROSS_MORPHOLOGY_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define BCM_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bcm assertion failed");

// When ante holds, cons must hold at the same edge.
`define BCM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcm assertion failed");

`else

`define BCM_ASSERT_ALWAYS(label, clk, rst, cond)
`define BCM_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

### rtl/bcm_pkg.sv
// Package: types and constants of the binary cross morphology block.
`default_nettype none

package bcm_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  localparam int LS_DEPTH = 1024;
  localparam int IDX_W    = $clog2(LS_DEPTH);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [WIDTH_REG_W-1:0]  MIN_WIDTH  = WIDTH_REG_W'(3);
  localparam logic [WIDTH_REG_W-1:0]  MAX_WIDTH  = WIDTH_REG_W'(LS_DEPTH);
  localparam logic [HEIGHT_REG_W-1:0] MIN_HEIGHT = HEIGHT_REG_W'(3);
  localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT = HEIGHT_REG_W'(4096);

  localparam logic [PIX_W-1:0]        THRESHOLD_RST = 8'd128;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST     = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST    = 13'd480;

  localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
  localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;

  // window bit = row*3 + col; row 0 is the upper line, col 0 the oldest column
  localparam logic [8:0] CROSS_MASK = 9'h0BA;
  localparam logic [8:0] SHIFT_MASK = 9'h0DB;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_WIDTH     = 2'd2,
    CFG_HEIGHT    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [PIX_W-1:0]        threshold;
    logic [WIDTH_REG_W-1:0]  frame_width;
    logic [HEIGHT_REG_W-1:0] frame_height;
  } front_cfg_t;

  // Classified pixel handed from front to back.
  typedef struct packed {
    logic             fg;
    logic [IDX_W-1:0] idx;
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               full;
    logic               empty;
  } fifo_status_t;

endpackage

`default_nettype wire

### rtl/bcm_pixel_if.sv
// Interfaces: pixel input channel and result output channel.
`default_nettype none

interface bcm_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [bcm_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface bcm_result_if;
  logic                      valid;
  logic                      ready;
  logic [bcm_pkg::PIX_W-1:0] value;
  logic [bcm_pkg::ROW_W-1:0] row;
  logic [bcm_pkg::COL_W-1:0] col;
  logic                      last;

  modport source (output valid, output value, output row, output col, output last,
                  input ready);
  modport sink (input valid, input value, input row, input col, input last,
                output ready);
endinterface

`default_nettype wire

### rtl/binary_cross_morphology.sv
// Top level: binary 3x3 cross erosion / dilation on a raster pixel stream.
//
// Usage:
//   pixels  - valid/ready input, one grayscale pixel per transfer in raster
//             order; frame_start on a transfer puts that pixel at row 0, col 0.
//   results - valid/ready output, one transfer per interior pixel (value 0 or
//             255, row, col, last). Border pixels produce no transfer.
//   cfg_we / cfg_index / cfg_data - register writes (mode, threshold,
//             frame_width, frame_height); write only while the block is idle.
// Throughput: one pixel per clock sustained while results are taken.
// Path: the result for centre (r-1, c-1) leaves the output register once the
//   pixel at (r, c) has passed the queue, the line store read register and
//   the window/output register.
// Reset: synchronous; clears position, window, queue and output valid and
//   loads the register defaults. Line stores are not cleared: every entry is
//   written on row 0 and 1 of a frame before a result uses it.
// Receiver stall: the output register holds; items pile up in the 4-entry
//   queue, then pixels.ready drops.
`default_nettype none

`include "binary_cross_morphology_defines.svh"

module binary_cross_morphology (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcm_pkg::CFG_DATA_W-1:0] cfg_data,
  bcm_pixel_if.sink                           pixels,
  bcm_result_if.source                        results
);

  bcm_pkg::mode_e        mode;
  bcm_pkg::front_cfg_t   front_cfg;
  logic                  push;
  logic                  pop;
  bcm_pkg::item_t        wr_item;
  bcm_pkg::item_t        rd_item;
  bcm_pkg::fifo_status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                   <= bcm_pkg::MODE_ERODE;
      front_cfg.threshold    <= bcm_pkg::THRESHOLD_RST;
      front_cfg.frame_width  <= bcm_pkg::WIDTH_RST;
      front_cfg.frame_height <= bcm_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bcm_pkg::CFG_MODE:      mode <= bcm_pkg::mode_e'(cfg_data[0]);
        bcm_pkg::CFG_THRESHOLD: front_cfg.threshold <= cfg_data[bcm_pkg::PIX_W-1:0];
        bcm_pkg::CFG_WIDTH:
          front_cfg.frame_width <= cfg_data[bcm_pkg::WIDTH_REG_W-1:0];
        bcm_pkg::CFG_HEIGHT:
          front_cfg.frame_height <= cfg_data[bcm_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // front: threshold and position; ready follows queue space
  bcm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (front_cfg),
    .pixels      (pixels),
    .queue_ready (!status.full),
    .push        (push),
    .item        (wr_item)
  );

  bcm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .status  (status)
  );

  // back: line stores, window and output register
  bcm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode),
    .q_item  (rd_item),
    .q_empty (status.empty),
    .pop     (pop),
    .results (results)
  );

  // the back end never pops an empty queue
  `BCM_ASSERT_ALWAYS(a_no_pop_empty, clk, rst, !(pop && status.empty))
  // a push without a pop grows the queue by exactly one
  `BCM_ASSERT_IMPL(a_fifo_grow, clk, rst, !$past(rst) && $past(push) && !$past(pop),
                   status.count == $past(status.count) + bcm_pkg::FIFO_CW'(1))
  // a result is pure foreground or background
  `BCM_ASSERT_IMPL(a_value_binary, clk, rst, results.valid,
                   results.value == bcm_pkg::FG_VALUE || results.value == bcm_pkg::BG_VALUE)
  // only interior centres are emitted
  `BCM_ASSERT_IMPL(a_interior, clk, rst, results.valid, results.row != '0 && results.col != '0)

endmodule

`default_nettype wire

### rtl/bcm_front.sv
// Front end: pixel transfer, threshold, raster position and emit decision.
`default_nettype none

module bcm_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bcm_pkg::front_cfg_t cfg,
  bcm_pixel_if.sink                pixels,
  input  wire logic                queue_ready,
  output logic                     push,
  output bcm_pkg::item_t           item
);

  logic [bcm_pkg::ROW_W-1:0]        row_count;
  logic [bcm_pkg::COL_W-1:0]        column_count;
  logic [bcm_pkg::ROW_W-1:0]        row_count_next;
  logic [bcm_pkg::COL_W-1:0]        column_count_next;
  logic [bcm_pkg::WIDTH_REG_W-1:0]  w_eff;
  logic [bcm_pkg::HEIGHT_REG_W-1:0] h_eff;
  logic [bcm_pkg::ROW_W-1:0]        r_cur;
  logic [bcm_pkg::COL_W-1:0]        c_cur;
  logic [bcm_pkg::WIDTH_REG_W-1:0]  c_inc;
  logic [bcm_pkg::HEIGHT_REG_W-1:0] r_inc;
  logic [bcm_pkg::HEIGHT_REG_W-1:0] r_adv;

  assign pixels.ready = queue_ready;
  assign push         = pixels.valid && queue_ready;

  always_comb begin
    // saturate geometry into the supported range
    w_eff = cfg.frame_width;
    if (w_eff < bcm_pkg::MIN_WIDTH) w_eff = bcm_pkg::MIN_WIDTH;
    if (w_eff > bcm_pkg::MAX_WIDTH) w_eff = bcm_pkg::MAX_WIDTH;
    h_eff = cfg.frame_height;
    if (h_eff < bcm_pkg::MIN_HEIGHT) h_eff = bcm_pkg::MIN_HEIGHT;
    if (h_eff > bcm_pkg::MAX_HEIGHT) h_eff = bcm_pkg::MAX_HEIGHT;

    if (pixels.frame_start) begin
      r_cur = '0;
      c_cur = '0;
    end else begin
      r_cur = row_count;
      c_cur = column_count;
    end

    item.fg   = (pixels.pixel >= cfg.threshold);
    item.idx  = c_cur;
    item.emit = (r_cur >= bcm_pkg::ROW_W'(2)) && (c_cur >= bcm_pkg::COL_W'(2)) &&
                ({1'b0, r_cur} < h_eff) && ({1'b0, c_cur} < w_eff);
    item.row  = r_cur - bcm_pkg::ROW_W'(1);
    item.col  = c_cur - bcm_pkg::COL_W'(1);
    item.last = ({1'b0, r_cur} == h_eff - bcm_pkg::HEIGHT_REG_W'(1)) &&
                ({1'b0, c_cur} == w_eff - bcm_pkg::WIDTH_REG_W'(1));

    c_inc = {1'b0, c_cur} + bcm_pkg::WIDTH_REG_W'(1);
    r_inc = {1'b0, r_cur} + bcm_pkg::HEIGHT_REG_W'(1);
    if (c_inc >= w_eff) begin
      column_count_next = '0;
      r_adv             = r_inc;
    end else begin
      column_count_next = c_inc[bcm_pkg::COL_W-1:0];
      r_adv             = {1'b0, r_cur};
    end
    if (r_adv >= h_eff) begin
      row_count_next = '0;
    end else begin
      row_count_next = r_adv[bcm_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
    end else if (push) begin
      row_count    <= row_count_next;
      column_count <= column_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/bcm_fifo.sv
// Short queue of classified pixels between front and back.
`default_nettype none

module bcm_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire bcm_pkg::item_t        wr_item,
  input  wire logic                  pop,
  output bcm_pkg::item_t             rd_item,
  output bcm_pkg::fifo_status_t      status
);

  bcm_pkg::item_t                slots [bcm_pkg::FIFO_DEPTH];
  logic [bcm_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [bcm_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [bcm_pkg::FIFO_CW-1:0]   count;

  assign rd_item      = slots[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == bcm_pkg::FIFO_CW'(bcm_pkg::FIFO_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + bcm_pkg::FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + bcm_pkg::FIFO_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + bcm_pkg::FIFO_CW'(1);
        2'b01:   count <= count - bcm_pkg::FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/bcm_back.sv
// Back end: line stores, 3x3 bit window, cross evaluation and output register.
`default_nettype none

module bcm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bcm_pkg::mode_e mode,
  input  wire bcm_pkg::item_t q_item,
  input  wire logic           q_empty,
  output logic                pop,
  bcm_result_if.source        results
);

  logic line_upper  [bcm_pkg::LS_DEPTH];
  logic line_middle [bcm_pkg::LS_DEPTH];

  logic           a_valid;
  bcm_pkg::item_t a_item;
  logic           rd_upper;
  logic           rd_middle;
  logic           a_adv;
  logic           bypass;
  logic [8:0]     window;
  logic [8:0]     window_next;
  logic [8:0]     cross_bits;
  logic           hit;

  logic                      o_valid;
  logic [bcm_pkg::PIX_W-1:0] o_value;
  logic [bcm_pkg::ROW_W-1:0] o_row;
  logic [bcm_pkg::COL_W-1:0] o_col;
  logic                      o_last;

  // stage A moves on unless it holds a result and the output register is stuck
  assign a_adv  = a_valid && (!a_item.emit || !o_valid || results.ready);
  assign pop    = !q_empty && (!a_valid || a_adv);
  assign bypass = a_adv && (a_item.idx == q_item.idx);

  always_comb begin
    window_next = ((window >> 1) & bcm_pkg::SHIFT_MASK) |
                  {a_item.fg, 2'b00, rd_middle, 2'b00, rd_upper, 2'b00};
    cross_bits = window_next & bcm_pkg::CROSS_MASK;
    case (mode)
      bcm_pkg::MODE_DILATE: hit = (cross_bits != '0);
      bcm_pkg::MODE_ERODE:  hit = (cross_bits == bcm_pkg::CROSS_MASK);
      default:              hit = 1'b0;
    endcase
  end

  // line stores: read on pop, written as the item leaves stage A
  always_ff @(posedge clk) begin
    if (a_adv) begin
      line_upper[a_item.idx]  <= rd_middle;
      line_middle[a_item.idx] <= a_item.fg;
    end
    if (pop) begin
      a_item    <= q_item;
      rd_upper  <= bypass ? rd_middle : line_upper[q_item.idx];
      rd_middle <= bypass ? a_item.fg : line_middle[q_item.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      window  <= '0;
    end else begin
      if (pop) a_valid <= 1'b1;
      else if (a_adv) a_valid <= 1'b0;
      if (a_adv) window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_adv && a_item.emit) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_item.emit) begin
      o_value <= hit ? bcm_pkg::FG_VALUE : bcm_pkg::BG_VALUE;
      o_row   <= a_item.row;
      o_col   <= a_item.col;
      o_last  <= a_item.last;
    end
  end

  assign results.valid = o_valid;
  assign results.value = o_value;
  assign results.row   = o_row;
  assign results.col   = o_col;
  assign results.last  = o_last;

endmodule

`default_nettype wire

### bench/bcm_checker.sv
`timescale 1ns / 1ps
// Checker for the binary cross morphology block: predicts each interior result and compares.
module bcm_checker
  import bcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  bcm_pixel_if                       pixels,
  bcm_result_if                      results,
  output int                         errors,
  output int                         pending,
  output int                         checked,
  output int                         frames
);

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cross_result_t;

  cross_result_t           expected_pixels[$];
  logic                    upper_line [LS_DEPTH];
  logic                    middle_line [LS_DEPTH];
  logic [8:0]              window;
  int                      next_row;
  int                      next_col;
  mode_e                   op_mode;
  logic [PIX_W-1:0]        thr_level;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      fail_count;
  int                      result_count;
  int                      frame_count;

  // Threshold one pixel, slide the window, queue the centre result if interior.
  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic mark);
    int            w;
    int            h;
    int            r;
    int            c;
    int            slot;
    logic          fg;
    logic          up;
    logic          mid;
    logic          hit;
    logic [8:0]    cross_bits;
    cross_result_t res;
    w = (width_reg < MIN_WIDTH) ? int'(MIN_WIDTH) :
        (width_reg > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(width_reg);
    h = (height_reg < MIN_HEIGHT) ? int'(MIN_HEIGHT) :
        (height_reg > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(height_reg);
    fg = (pix >= thr_level);
    if (mark) begin
      next_row = 0;
      next_col = 0;
    end
    r    = next_row;
    c    = next_col;
    slot = c % LS_DEPTH;
    up   = upper_line[slot];
    mid  = middle_line[slot];
    // new column enters at bits 2/5/8, oldest column drops out
    window = ((window >> 1) & SHIFT_MASK) | {fg, 2'b00, mid, 2'b00, up, 2'b00};
    upper_line[slot]  = mid;
    middle_line[slot] = fg;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      cross_bits = window & CROSS_MASK;
      hit        = (op_mode == MODE_ERODE) ? (cross_bits == CROSS_MASK) :
                                             (cross_bits != 9'd0);
      res.value  = hit ? FG_VALUE : BG_VALUE;
      res.row    = ROW_W'(r - 1);
      res.col    = COL_W'(c - 1);
      res.last   = (r == h - 1) && (c == w - 1);
      expected_pixels.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    next_row = r;
    next_col = c;
  endtask

  always @(posedge clk) begin : watch
    cross_result_t want;
    cross_result_t got;
    if (rst) begin
      expected_pixels.delete();
      for (int i = 0; i < LS_DEPTH; i++) begin
        upper_line[i]  = 1'b0;
        middle_line[i] = 1'b0;
      end
      window       = '0;
      next_row     = 0;
      next_col     = 0;
      op_mode      = MODE_ERODE;
      thr_level    = THRESHOLD_RST;
      width_reg    = WIDTH_RST;
      height_reg   = HEIGHT_RST;
      fail_count   = 0;
      result_count = 0;
      frame_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          CFG_MODE:      op_mode    = mode_e'(cfg_data[0]);
          CFG_THRESHOLD: thr_level  = cfg_data[PIX_W-1:0];
          CFG_WIDTH:     width_reg  = cfg_data[WIDTH_REG_W-1:0];
          CFG_HEIGHT:    height_reg = cfg_data[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) predict_pixel(pixels.pixel, pixels.frame_start);
      if (results.valid && results.ready) begin
        got = {results.value, results.row, results.col, results.last};
        result_count++;
        if (got.last === 1'b1) frame_count++;
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: value %0d row %0d col %0d last %0b",
                   $time, got.value, got.row, got.col, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.value !== want.value || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last) begin
            fail_count++;
            $display("%0t: mismatch (value/row/col/last) exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     $time, want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
          end
        end
      end
    end
    errors  <= fail_count;
    pending <= expected_pixels.size();
    checked <= result_count;
    frames  <= frame_count;
  end

endmodule

### bench/binary_cross_morphology_tb.sv
`timescale 1ns / 1ps
// Testbench top: stimulus, handshake idling, register settings and verdict for the block.
module binary_cross_morphology_tb;
  import bcm_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;   // far beyond the slowest legal run
  localparam int HOLD_CYCLES  = 100;       // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;         // margin for the output path to drain

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          errors;
  int          pending;
  int          checked;
  int          frames;
  int unsigned cycle_count;
  int          pixels_sent;
  int          settings_used;
  int          cur_width = int'(WIDTH_RST);

  // idling controls for the sender and receiver processes
  bit tx_calm;
  bit rx_calm;
  bit rx_hold_req;

  // Directed frame, 5 wide by 4 high, thresholded at the reset level of 128.
  // Values straddle the threshold (127/128) and include 0 and 255; the interior
  // gives a mix of full crosses and broken ones.
  logic [PIX_W-1:0] sample_frame [20] = '{
    8'd0,   8'd200, 8'd255, 8'd128, 8'd9,
    8'd255, 8'd128, 8'd255, 8'd200, 8'd255,
    8'd131, 8'd255, 8'd128, 8'd255, 8'd127,
    8'd12,  8'd255, 8'd129, 8'd250, 8'd0
  };

  bcm_pixel_if  pix_ch ();
  bcm_result_if res_ch ();

  binary_cross_morphology uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch)
  );

  bcm_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .frames    (frames)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binary_cross_morphology_tb failed");
      $finish;
    end
  end

  // Result receiver. Random stall bursts unless calm; a hold request from the
  // stimulus gives one long stall so the internal queue fills and the input
  // channel backs up.
  initial begin : receiver
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // One register write per clock; the caller drops cfg_we after the last one
  // so back-to-back writes never toggle it within a step.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Full register setting. Unused upper data bits carry junk: the block must
  // keep only each register's own width. Reports whether the effective width
  // grew, since a wider row would read line store entries never written.
  task automatic configure(input mode_e md, input logic [PIX_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data, output bit grew);
    int next_width;
    next_width = int'(w_data[WIDTH_REG_W-1:0]);
    if (next_width < 3) next_width = 3;
    else if (next_width > LS_DEPTH) next_width = LS_DEPTH;
    grew      = next_width > cur_width;
    cur_width = next_width;
    write_reg(CFG_MODE, {12'($urandom), md});
    write_reg(CFG_THRESHOLD, {5'($urandom), thr});
    write_reg(CFG_WIDTH, {2'($urandom), w_data[WIDTH_REG_W-1:0]});
    write_reg(CFG_HEIGHT, h_data);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Pixel on one side of the threshold or the other, foreground with the
  // given percentage; a zero threshold makes every value foreground.
  function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] thr,
                                                  input int fg_pct);
    if (thr == 8'd0 || $urandom_range(0, 99) < fg_pct)
      return PIX_W'($urandom_range(255, int'(thr)));
    return PIX_W'($urandom_range(int'(thr) - 1, 0));
  endfunction

  // One pixel transfer, optionally preceded by a random gap. Valid stays high
  // afterwards so consecutive calls stream without a bubble.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic mark);
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pix;
    pix_ch.frame_start <= mark;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    pixels_sent++;
  endtask

  // Stop offering, wait for every predicted result, then let the pipeline
  // finish any border pixel still in flight.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A register setting followed by a stream of pixels. The first pixel marks a
  // frame start when asked or when the row got wider; stray marks restart the
  // frame mid-stream.
  task automatic run_phase(input mode_e md, input logic [PIX_W-1:0] thr,
                           input int w_val, input int h_val, input int count,
                           input int fg_pct, input bit restart, input bit stray_marks);
    bit grew;
    bit mark;
    configure(md, thr, CFG_DATA_W'(w_val), CFG_DATA_W'(h_val), grew);
    for (int i = 0; i < count; i++) begin
      if (i == 0) mark = restart || grew;
      else mark = stray_marks && ($urandom_range(0, 49) == 0);
      send_pixel(pick_pixel(thr, fg_pct), mark);
    end
    settle();
  endtask

  initial begin : stimulus
    bit               grew;
    mode_e            mode_pick;
    logic [PIX_W-1:0] thr_pick;
    int               w_pick;
    int               h_pick;
    int               fg_pick;

    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.frame_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_MODE;
    cfg_data           <= '0;
    rst                <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame: only the geometry is written, so mode and threshold
    // still hold their reset values (erosion, 128).
    write_reg(CFG_WIDTH, CFG_DATA_W'(5));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(4));
    cfg_we <= 1'b0;
    cur_width = 5;
    settings_used++;
    foreach (sample_frame[i]) send_pixel(sample_frame[i], i == 0);
    settle();

    // Geometry below the minimum saturates to 3x3: three frames back to back
    // with no marks between them, one result each. Zero threshold: all set.
    run_phase(MODE_DILATE, 8'd0, 2, 0, 27, 50, 1'b1, 1'b0);
    // Top threshold: only 255 counts as foreground.
    run_phase(MODE_ERODE, 8'd255, 12, 9, 45, 90, 1'b0, 1'b1);

    // Geometry shrunk mid-frame. 43 pixels of a 16-wide frame leave the
    // position at row 2, column 11; at width 6 that column is past the row end
    // and wraps to the next row. A later height of 3 puts the row past the
    // frame end, which wraps to row 0.
    run_phase(MODE_DILATE, 8'd90, 16, 10, 43, 20, 1'b1, 1'b0);
    run_phase(MODE_ERODE, 8'd90, 6, 10, 20, 80, 1'b0, 1'b0);
    run_phase(MODE_DILATE, 8'd170, 6, 3, 30, 30, 1'b0, 1'b0);

    // Random settings, mostly small frames; a few saturating sizes.
    for (int p = 0; p < 6; p++) begin
      mode_pick = mode_e'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       thr_pick = 8'd0;
        1:       thr_pick = 8'd255;
        default: thr_pick = PIX_W'($urandom_range(1, 254));
      endcase
      w_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      h_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      case ($urandom_range(0, 2))
        0:       fg_pick = 15;
        1:       fg_pick = 50;
        default: fg_pick = 85;
      endcase
      run_phase(mode_pick, thr_pick, w_pick, h_pick, $urandom_range(15, 30), fg_pick,
                1'($urandom_range(0, 1)), 1'b1);
    end

    // Back-pressure: the receiver stalls for a long stretch while the sender
    // streams without gaps, so the block backs up into its input. Later the
    // sender pauses until every predicted result has been taken.
    configure(MODE_DILATE, 8'd100, CFG_DATA_W'(12), CFG_DATA_W'(12), grew);
    for (int i = 0; i < 100; i++) begin
      tx_calm = (i >= 20 && i < 70);
      if (i == 20) rx_hold_req = 1'b1;
      if (i == 70) begin
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_pixel(pick_pixel(8'd100, 40), i == 0);
    end
    tx_calm = 1'b0;
    settle();

    // Widest row: an 11-bit width of 2047 saturates to the line store depth.
    // The stream stays within row 0, so nothing may come out.
    run_phase(MODE_ERODE, PIX_W'($urandom_range(1, 254)), 2047, 3, 30, 70,
              1'b1, 1'b0);
    // Tallest frame: height 8191 saturates to 4096 rows of width 3; ten rows
    // in, no result may carry a frame end.
    run_phase(MODE_DILATE, PIX_W'($urandom_range(1, 254)), 1, 8191, 30, 20,
              1'b1, 1'b0);

    // Closing stretch with both sides streaming flat out.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_phase(MODE_ERODE, 8'd128, 7, 5, 40, 85, 1'b0, 1'b1);
    run_phase(MODE_DILATE, 8'd60, 3, 4, 30, 15, 1'b1, 1'b1);

    $display("Run covered %0d pixels over %0d register settings (erosion, dilation,",
             pixels_sent, settings_used);
    $display("  saturated and shrunk geometry); %0d results checked, %0d frame ends seen",
             checked, frames);
    if (errors == 0) begin
      $display("binary_cross_morphology_tb passed");
    end else begin
      $display("binary_cross_morphology_tb failed");
    end
    $finish;
  end

endmodule
